### rtl/core/hcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_pkg: shared types and constants of the hold-count selector
// Field widths, action codes, flash codes and the selector state record.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int BASE_W     = 7;
    localparam int TICK_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int BANK_W     = 2;
    localparam int FLASH_W    = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TICK_W-1:0]  TICK_MAX   = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd11;
    localparam logic [BASE_W-1:0]  BASE_RESET = 7'd10;

    // register index taken from the word address bit of paddr
    localparam logic REG_HOLD_BASE = 1'b0;

    typedef enum logic [FLASH_W-1:0] {
        FLASH_NONE  = 2'd0,
        FLASH_STEP  = 2'd1,
        FLASH_RESET = 2'd2
    } flash_t;

    typedef enum logic [COUNT_W-1:0] {
        ACT_RESET     = 4'd1,
        ACT_BANK_NEXT = 4'd2,
        ACT_DRIVE     = 4'd3,
        ACT_BANK0     = 4'd4,
        ACT_BANK1     = 4'd5,
        ACT_BANK2     = 4'd6,
        ACT_BANK3     = 4'd7,
        ACT_RESET_SND = 4'd8,
        ACT_START_SND = 4'd9,
        ACT_LONG_WAIT = 4'd10,
        ACT_MUTE      = 4'd11
    } action_t;

    typedef struct packed {
        logic [TICK_W-1:0]  hold_ticks;
        logic [COUNT_W-1:0] step_count;
        logic [BANK_W-1:0]  bank;
        logic               drive;
        logic               reset_flash_en;
        logic               start_flash_en;
        logic               long_wait;
        logic               muted;
    } hcs_state_t;

    typedef struct packed {
        logic   reset_pulse;
        flash_t led_flash;
        logic   settings_changed;
    } hcs_event_t;

    localparam hcs_state_t STATE_RESET = '{
        hold_ticks:     '0,
        step_count:     '0,
        bank:           '0,
        drive:          1'b0,
        reset_flash_en: 1'b1,
        start_flash_en: 1'b1,
        long_wait:      1'b0,
        muted:          1'b0
    };

endpackage

### rtl/core/hcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_if: valid/ready channels of the hold-count selector
// Sample channel carries one button level per word; result channel carries
// the current selections, settings and event flags.
// ----------------------------------------------------------------------------
interface hcs_in_if;
    logic valid;
    logic ready;
    logic button_pressed;

    modport source (output valid, output button_pressed, input ready);
    modport sink   (input valid, input button_pressed, output ready);
endinterface

interface hcs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kernal_select;
    logic       drive_select;
    logic       reset_pulse;
    logic [1:0] led_flash;
    logic       settings_changed;
    logic       reset_sound_on;
    logic       start_sound_on;
    logic       long_wait_on;
    logic       mute_on;
    logic [3:0] press_count;

    modport source (
        output valid, output kernal_select, output drive_select, output reset_pulse,
        output led_flash, output settings_changed, output reset_sound_on,
        output start_sound_on, output long_wait_on, output mute_on, output press_count,
        input ready
    );
    modport sink (
        input valid, input kernal_select, input drive_select, input reset_pulse,
        input led_flash, input settings_changed, input reset_sound_on,
        input start_sound_on, input long_wait_on, input mute_on, input press_count,
        output ready
    );
endinterface

### rtl/core/hcs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_cfg: APB register file of the hold-count selector
// Holds the hold tick base; zero wait states, reads return the register.
// ----------------------------------------------------------------------------
module hcs_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hcs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hcs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hcs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [hcs_pkg::BASE_W-1:0]      hold_base
);
    import hcs_pkg::*;

    logic [BASE_W-1:0] base_reg;
    logic              base_wr;

    assign pready  = 1'b1;
    assign base_wr = psel && penable && pwrite && (paddr[2] == REG_HOLD_BASE);

    // hold base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (base_wr)
        begin
            base_reg <= pwdata[BASE_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_HOLD_BASE)
        begin
            prdata = {{(APB_DATA_W-BASE_W){1'b0}}, base_reg};
        end
    end

    assign hold_base = base_reg;

endmodule

### rtl/core/hcs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_step: per-tick update of the hold-count selector
// Runs the hold counter, steps the press count and decodes the action on
// release; produces the next state and this tick's event flags.
// ----------------------------------------------------------------------------
module hcs_step (
    input  hcs_pkg::hcs_state_t          state,
    input  logic [hcs_pkg::BASE_W-1:0]   hold_base,
    input  logic                         button_pressed,
    output hcs_pkg::hcs_state_t          state_next,
    output hcs_pkg::hcs_event_t          evt
);
    import hcs_pkg::*;

    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] ticks_inc;

    // limit doubles with long wait
    assign limit = state.long_wait ? {hold_base, 1'b0} : {1'b0, hold_base};
    assign ticks_inc = (state.hold_ticks == TICK_MAX) ? TICK_MAX
                                                      : state.hold_ticks + 1'b1;

    always_comb
    begin
        state_next = state;
        evt.reset_pulse      = 1'b0;
        evt.led_flash        = FLASH_NONE;
        evt.settings_changed = 1'b0;

        if (button_pressed)
        begin
            // count ticks, advance the press count past the limit
            state_next.hold_ticks = ticks_inc;
            if (ticks_inc > limit)
            begin
                if (state.step_count < COUNT_MAX)
                begin
                    state_next.step_count = state.step_count + 1'b1;
                end
                state_next.hold_ticks = '0;
                if (!state.muted)
                begin
                    evt.led_flash = FLASH_STEP;
                end
            end
        end
        else
        begin
            state_next.hold_ticks = '0;
            if (state.step_count != '0)
            begin
                // release with a count: run the selected action
                evt.settings_changed = 1'b1;
                case (action_t'(state.step_count))
                    ACT_BANK_NEXT: state_next.bank = state.bank + 1'b1;
                    ACT_DRIVE:     state_next.drive = ~state.drive;
                    ACT_BANK0, ACT_BANK1, ACT_BANK2, ACT_BANK3:
                        state_next.bank = state.step_count[BANK_W-1:0];
                    ACT_RESET_SND: state_next.reset_flash_en = ~state.reset_flash_en;
                    ACT_START_SND: state_next.start_flash_en = ~state.start_flash_en;
                    ACT_LONG_WAIT: state_next.long_wait = ~state.long_wait;
                    ACT_MUTE:      state_next.muted = ~state.muted;
                    default:       evt.settings_changed = 1'b0;
                endcase
                state_next.step_count = '0;
                evt.reset_pulse = 1'b1;
                // flash judged on the settings after the action
                if (state_next.reset_flash_en && !state_next.muted)
                begin
                    evt.led_flash = FLASH_RESET;
                end
            end
        end
    end

endmodule

### rtl/core/switchless_hold_count_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switchless_hold_count_selector: button hold-count action selector
// Counts hold time in button ticks, selects ROM bank, drive and settings.
// ----------------------------------------------------------------------------
// Usage:
//   sample (sink): one word per button tick, button_pressed = 1 while held.
//   result (source): one word per sample with the bank and drive selects,
//     the four settings, the press count, and the reset pulse, flash code
//     and settings-changed flags of that tick.
//   APB: register 0 at byte address 0 holds the hold tick base (7 bits,
//     reset 10); write it only while no sample is in flight.
// A sample is taken into the sample register, passes the step logic and is
// registered in the result register, which drives the result channel. One
// sample per cycle is sustained while the result side is ready; the step
// logic between the two registers is combinational.
// When the result side stalls, the result register holds and the sample
// register fills; ready drops only when both are occupied.
// Reset clears both stages and returns bank 0, drive 0, reset and start
// flashes on, long wait and mute off, and a base of 10.
// ----------------------------------------------------------------------------
module switchless_hold_count_selector (
    input  logic                            clk,
    input  logic                            rst_n,
    hcs_in_if.sink                          sample,
    hcs_out_if.source                       result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hcs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hcs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hcs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import hcs_pkg::*;

    logic [BASE_W-1:0] hold_base;
    hcs_state_t        state_reg;
    hcs_state_t        state_next;
    hcs_event_t        evt_next;
    hcs_state_t        out_state_reg;
    hcs_event_t        out_evt_reg;
    logic              in_valid_reg;
    logic              in_button_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              fire;

    hcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .hold_base (hold_base)
    );

    hcs_step u_step (
        .state          (state_reg),
        .hold_base      (hold_base),
        .button_pressed (in_button_reg),
        .state_next     (state_next),
        .evt            (evt_next)
    );

    // handshake: move forward whenever the result slot frees up
    assign advance      = !out_valid_reg || result.ready;
    assign fire         = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;

    // sample register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            in_button_reg <= sample.button_pressed;
        end
    end

    // selector state, updated once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_state_reg <= state_next;
            out_evt_reg   <= evt_next;
        end
    end

    // drive result word
    assign result.valid            = out_valid_reg;
    assign result.kernal_select    = out_state_reg.bank;
    assign result.drive_select     = out_state_reg.drive;
    assign result.reset_pulse      = out_evt_reg.reset_pulse;
    assign result.led_flash        = out_evt_reg.led_flash;
    assign result.settings_changed = out_evt_reg.settings_changed;
    assign result.reset_sound_on   = out_state_reg.reset_flash_en;
    assign result.start_sound_on   = out_state_reg.start_flash_en;
    assign result.long_wait_on     = out_state_reg.long_wait;
    assign result.mute_on          = out_state_reg.muted;
    assign result.press_count      = out_state_reg.step_count;

`ifndef SYNTHESIS
    // press count never passes its saturation point
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_state_reg.step_count <= COUNT_MAX))
        else $error("press count above maximum");

    // an action always clears the press count
    a_pulse_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_evt_reg.reset_pulse) |-> (out_state_reg.step_count == '0))
        else $error("reset pulse with nonzero press count");

    // a settings change only comes with an action
    a_changed_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_evt_reg.settings_changed) |-> out_evt_reg.reset_pulse)
        else $error("settings change without reset pulse");

    // state moves only when a sample is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("state changed without a processed sample");
`endif

endmodule

### sim/tb_switchless_hold_count_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_switchless_hold_count_selector: self-checking bench of the selector
// Drives button ticks over the sample channel and compares every result word
// against a cycle-free model of the hold counter and action decode, or a
// typed table row. A short directed tick table runs first at a base of zero;
// random hold/release sequences follow over several bases, with random gaps
// on both sides, a long result stall and full drains between base changes.
// ----------------------------------------------------------------------------
module tb_switchless_hold_count_selector;

    import hcs_pkg::*;

    // one result word as the selector reports it
    typedef struct packed {
        logic [BANK_W-1:0]  kernal;
        logic               drive;
        logic               pulse;
        flash_t             flash;
        logic               changed;
        logic               reset_snd;
        logic               start_snd;
        logic               long_wait;
        logic               mute;
        logic [COUNT_W-1:0] count;
    } sel_word_t;

    // one row of the directed tick table
    typedef struct packed {
        logic      btn;
        logic      typed;
        sel_word_t want;
    } tick_row_t;

    localparam sel_word_t W_IDLE = '{kernal: 2'd0, drive: 1'b0, pulse: 1'b0,
        flash: FLASH_NONE, changed: 1'b0, reset_snd: 1'b1, start_snd: 1'b1,
        long_wait: 1'b0, mute: 1'b0, count: 4'd0};
    localparam sel_word_t W_COUNT1 = '{kernal: 2'd0, drive: 1'b0, pulse: 1'b0,
        flash: FLASH_STEP, changed: 1'b0, reset_snd: 1'b1, start_snd: 1'b1,
        long_wait: 1'b0, mute: 1'b0, count: 4'd1};
    localparam sel_word_t W_RESET_ACT = '{kernal: 2'd0, drive: 1'b0, pulse: 1'b1,
        flash: FLASH_RESET, changed: 1'b0, reset_snd: 1'b1, start_snd: 1'b1,
        long_wait: 1'b0, mute: 1'b0, count: 4'd0};
    localparam sel_word_t W_MUTE_ACT = '{kernal: 2'd0, drive: 1'b0, pulse: 1'b1,
        flash: FLASH_NONE, changed: 1'b1, reset_snd: 1'b1, start_snd: 1'b1,
        long_wait: 1'b0, mute: 1'b1, count: 4'd0};

    localparam int TICK_ROWS = 26;
    localparam int RANDOM_TICKS = 1800;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD_CYCLES = 150;

    // base of zero: every held tick is one count step
    localparam tick_row_t TICK_TABLE [TICK_ROWS] = '{
        '{1'b0, 1'b1, W_IDLE},          // reset state, nothing held
        '{1'b1, 1'b1, W_COUNT1},        // one step, step flash
        '{1'b0, 1'b1, W_RESET_ACT},     // reset-only action, reset flash
        '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE},
        '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE},
        '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE},
        '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE},
        '{1'b1, 1'b0, W_IDLE},          // twelfth step, count stays at 11
        '{1'b0, 1'b1, W_MUTE_ACT},      // mute toggle silences its own flash
        '{1'b1, 1'b0, W_IDLE},          // step while muted
        '{1'b0, 1'b0, W_IDLE},
        '{1'b0, 1'b0, W_IDLE},          // release with nothing counted
        '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE},
        '{1'b0, 1'b0, W_IDLE},          // next bank
        '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE}, '{1'b1, 1'b0, W_IDLE},
        '{1'b0, 1'b0, W_IDLE}           // drive toggle
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hcs_in_if  sample_ch ();
    hcs_out_if result_ch ();

    switchless_hold_count_selector uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // selector model state
    logic [BASE_W-1:0] hold_base;
    hcs_state_t        sel_state;

    sel_word_t owed_words [$];
    int        fails = 0;
    int        words_seen = 0;
    int        ticks_fed = 0;
    bit        burst = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // count a mismatch, print the first few
    task automatic report(input string what);
        fails++;
        if (fails <= 40)
            $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // advance the selector model by one tick and return its result word
    function automatic sel_word_t advance_selector(input logic btn);
        sel_word_t w;
        int        limit;
        w = '0;
        w.flash = FLASH_NONE;
        if (btn)
        begin
            limit = int'(hold_base) * (1 + int'(sel_state.long_wait));
            if (sel_state.hold_ticks < TICK_MAX)
                sel_state.hold_ticks++;
            if (int'(sel_state.hold_ticks) > limit)
            begin
                if (sel_state.step_count < COUNT_MAX)
                    sel_state.step_count++;
                sel_state.hold_ticks = '0;
                if (!sel_state.muted)
                    w.flash = FLASH_STEP;
            end
        end
        else
        begin
            sel_state.hold_ticks = '0;
            if (sel_state.step_count != '0)
            begin
                w.changed = 1'b1;
                case (action_t'(sel_state.step_count))
                    ACT_BANK_NEXT: sel_state.bank = sel_state.bank + 2'd1;
                    ACT_DRIVE:     sel_state.drive = ~sel_state.drive;
                    ACT_BANK0, ACT_BANK1, ACT_BANK2, ACT_BANK3:
                        sel_state.bank = BANK_W'(sel_state.step_count - ACT_BANK0);
                    ACT_RESET_SND: sel_state.reset_flash_en = ~sel_state.reset_flash_en;
                    ACT_START_SND: sel_state.start_flash_en = ~sel_state.start_flash_en;
                    ACT_LONG_WAIT: sel_state.long_wait = ~sel_state.long_wait;
                    ACT_MUTE:      sel_state.muted = ~sel_state.muted;
                    default:       w.changed = 1'b0;
                endcase
                sel_state.step_count = '0;
                w.pulse = 1'b1;
                if (sel_state.reset_flash_en && !sel_state.muted)
                    w.flash = FLASH_RESET;
            end
        end
        w.kernal    = sel_state.bank;
        w.drive     = sel_state.drive;
        w.reset_snd = sel_state.reset_flash_en;
        w.start_snd = sel_state.start_flash_en;
        w.long_wait = sel_state.long_wait;
        w.mute      = sel_state.muted;
        w.count     = sel_state.step_count;
        return w;
    endfunction

    // pick a sender gap: mostly none, some short, a few long
    function automatic int sender_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // offer one tick, hold it until accepted, then log its expected word
    task automatic send_tick(input logic btn, input logic typed, input sel_word_t want);
        int        gap;
        sel_word_t w;
        gap = sender_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.button_pressed <= btn;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        w = advance_selector(btn);
        owed_words.push_back(typed ? want : w);
        ticks_fed++;
    endtask

    // drop valid and wait until every word has come back
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == {REG_HOLD_BASE, 2'b00})
            hold_base = data[BASE_W-1:0];
    endtask

    task automatic set_base(input int base);
        logic [APB_DATA_W-1:0] data;
        data = $urandom;
        data[BASE_W-1:0] = BASE_W'(base);
        write_reg({REG_HOLD_BASE, 2'b00}, data);
    endtask

    // one random press: mostly clean holds to a count, some noise
    task automatic random_press();
        int limit;
        int steps;
        int hold;
        int r;
        limit = int'(hold_base) * (1 + int'(sel_state.long_wait));
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            repeat ($urandom_range(1, 8))
                send_tick(1'($urandom_range(0, 1)), 1'b0, W_IDLE);
        end
        else if (r == 1)
        begin
            // let go before, or just as, the first step completes
            repeat ($urandom_range(1, limit + 1))
                send_tick(1'b1, 1'b0, W_IDLE);
            send_tick(1'b0, 1'b0, W_IDLE);
        end
        else
        begin
            steps = (limit > 40) ? $urandom_range(1, 2) : $urandom_range(1, 12);
            hold = steps * (limit + 1) + $urandom_range(0, limit);
            repeat (hold)
                send_tick(1'b1, 1'b0, W_IDLE);
            repeat ($urandom_range(1, 3))
                send_tick(1'b0, 1'b0, W_IDLE);
        end
    endtask

    // result receiver: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int  stall;
        int  quiet;
        int  r;
        bit  held_off;
        stall = 0;
        quiet = 0;
        held_off = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && words_seen >= LONG_HOLD_AT)
            begin
                held_off = 1'b1;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (quiet > 0)
                    quiet--;
                else
                begin
                    r = $urandom_range(0, 199);
                    if (r < 2)
                        quiet = 60;
                    else if (r < 130)
                        stall = 0;
                    else if (r < 185)
                        stall = $urandom_range(1, 3);
                    else
                        stall = $urandom_range(8, 30);
                end
            end
            @(posedge clk);
        end
    end

    // compare each accepted word with the oldest one owed
    always @(posedge clk)
    begin
        sel_word_t got;
        sel_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{kernal: result_ch.kernal_select, drive: result_ch.drive_select,
                pulse: result_ch.reset_pulse, flash: flash_t'(result_ch.led_flash),
                changed: result_ch.settings_changed, reset_snd: result_ch.reset_sound_on,
                start_snd: result_ch.start_sound_on, long_wait: result_ch.long_wait_on,
                mute: result_ch.mute_on, count: result_ch.press_count};
            words_seen++;
            if (owed_words.size() == 0)
                report($sformatf("word %0d arrived with none owed", words_seen));
            else
            begin
                want = owed_words.pop_front();
                if (got.kernal !== want.kernal)
                    report($sformatf("word %0d kernal_select %0d, want %0d",
                        words_seen, got.kernal, want.kernal));
                if (got.drive !== want.drive)
                    report($sformatf("word %0d drive_select %0d, want %0d",
                        words_seen, got.drive, want.drive));
                if (got.pulse !== want.pulse)
                    report($sformatf("word %0d reset_pulse %0d, want %0d",
                        words_seen, got.pulse, want.pulse));
                if (got.flash !== want.flash)
                    report($sformatf("word %0d led_flash %0d, want %0d",
                        words_seen, got.flash, want.flash));
                if (got.changed !== want.changed)
                    report($sformatf("word %0d settings_changed %0d, want %0d",
                        words_seen, got.changed, want.changed));
                if (got.reset_snd !== want.reset_snd)
                    report($sformatf("word %0d reset_sound_on %0d, want %0d",
                        words_seen, got.reset_snd, want.reset_snd));
                if (got.start_snd !== want.start_snd)
                    report($sformatf("word %0d start_sound_on %0d, want %0d",
                        words_seen, got.start_snd, want.start_snd));
                if (got.long_wait !== want.long_wait)
                    report($sformatf("word %0d long_wait_on %0d, want %0d",
                        words_seen, got.long_wait, want.long_wait));
                if (got.mute !== want.mute)
                    report($sformatf("word %0d mute_on %0d, want %0d",
                        words_seen, got.mute, want.mute));
                if (got.count !== want.count)
                    report($sformatf("word %0d press_count %0d, want %0d",
                        words_seen, got.count, want.count));
            end
        end
    end

    // stimulus
    initial
    begin
        int phase;
        int stop_at;
        rst_n                    = 1'b0;
        sample_ch.valid          = 1'b0;
        sample_ch.button_pressed = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        hold_base                = BASE_RESET;
        sel_state                = STATE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at a base of zero
        set_base(0);
        for (int i = 0; i < TICK_ROWS; i++)
            send_tick(TICK_TABLE[i].btn, TICK_TABLE[i].typed, TICK_TABLE[i].want);

        // random presses over a range of bases
        phase = 0;
        ticks_fed = 0;
        while (ticks_fed < RANDOM_TICKS)
        begin
            wait_idle();
            case (phase)
                0:       set_base(127);
                1:       set_base(1);
                2:       set_base(0);
                default: set_base((phase % 4 == 3) ? $urandom_range(7, 127)
                                                   : $urandom_range(0, 6));
            endcase
            burst = ($urandom_range(0, 3) == 0);
            stop_at = ticks_fed + $urandom_range(150, 250);
            while (ticks_fed < stop_at)
            begin
                random_press();
                // hold the sender once mid-phase until all words are back
                if (phase == 1 && ticks_fed >= stop_at - 100)
                begin
                    wait_idle();
                    phase = phase + 100;
                end
            end
            phase = (phase >= 100) ? phase - 99 : phase + 1;
        end

        // flush out and judge
        wait_idle();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop on a hung handshake
    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/core/hcs_pkg.sv
rtl/core/hcs_if.sv
rtl/core/hcs_cfg.sv
rtl/core/hcs_step.sv
rtl/core/switchless_hold_count_selector.sv
sim/tb_switchless_hold_count_selector.sv
